// File: hdl/config_text_tokenizer_top_macros.svh
// Assertion macros used by the tokenizer lexer (ctt_lex).
// The asserting module must have i_clk and a synchronous active-low i_rst_n.
`ifndef CONFIG_TEXT_TOKENIZER_TOP_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CTT_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTT_ASSERT(label, ante, cons, msg)
`define CTT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hdl/ctt_pkg.sv
`timescale 1ns / 1ps

package ctt_pkg;

    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_TOKEN   = 2'd2,
        MODE_ESCAPE  = 2'd3
    } t_lex_mode;

    typedef struct packed {
        logic       emit;
        logic       char_valid;
        logic [7:0] token_char;
        logic       token_end;
    } t_lex_result;

    function automatic logic is_separator(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) ||
               (c == CH_COLON) || (c == CH_COMMA);
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return (c == CH_LBRACK) || (c == CH_RBRACK);
    endfunction

endpackage

// File: hdl/ctt_stream_if.sv
`timescale 1ns / 1ps

interface ctt_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface ctt_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] token_char;
    logic       token_end;

    modport source (output valid, output char_valid, output token_char,
                    output token_end, input ready);
    modport sink   (input valid, input char_valid, input token_char,
                    input token_end, output ready);
endinterface

// File: hdl/config_text_tokenizer_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                              Word
// i_in      in   action, data_byte                    one text byte or end of stream
// o_out     out  char_valid, token_char, token_end    zero or one per input word
//
// One input word per cycle sustained while o_out does not stall; each word is taken
// into the input register, then the lexer decodes its result into the output register.
// Reset clears lexer mode, quoted span and both valid flags.
// A word that makes no result leaves the input register even while o_out stalls;
// a word with a result waits there until the output register frees up.

module config_text_tokenizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctt_in_if.sink     i_in,
    ctt_out_if.source  o_out
);

    logic       r_s1_valid;
    logic       r_s1_action;
    logic [7:0] r_s1_byte;

    ctt_pkg::t_lex_result s1_result;
    logic                 out_free;
    logic                 s1_move;

    assign s1_move    = r_s1_valid && (!s1_result.emit || out_free);
    assign i_in.ready = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_action <= i_in.action;
            r_s1_byte   <= i_in.data_byte;
        end
    end

    ctt_lex u_lex (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_move),
        .i_action    (r_s1_action),
        .i_data_byte (r_s1_byte),
        .o_result    (s1_result)
    );

    ctt_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_move && s1_result.emit),
        .i_word  (s1_result),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

// File: hdl/ctt_lex.sv
`timescale 1ns / 1ps
`include "config_text_tokenizer_top_macros.svh"

module ctt_lex (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_action,
    input  logic [7:0]           i_data_byte,
    output ctt_pkg::t_lex_result o_result
);

    ctt_pkg::t_lex_mode r_mode, n_mode;
    logic               r_quoted, n_quoted;

    logic c_sep, c_brk, c_hash, c_bslash, c_quote;

    assign c_sep    = ctt_pkg::is_separator(i_data_byte);
    assign c_brk    = ctt_pkg::is_bracket(i_data_byte);
    assign c_hash   = (i_data_byte == ctt_pkg::CH_HASH);
    assign c_bslash = (i_data_byte == ctt_pkg::CH_BSLASH);
    assign c_quote  = (i_data_byte == ctt_pkg::CH_QUOTE);

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_quoted = r_quoted;
        if (i_action == ctt_pkg::ACT_EOS) begin
            n_mode   = ctt_pkg::MODE_IDLE;
            n_quoted = 1'b0;
        end else begin
            unique case (r_mode)
                ctt_pkg::MODE_IDLE: begin
                    n_quoted = 1'b0;
                    if (c_hash) begin
                        n_mode = ctt_pkg::MODE_COMMENT;
                    end else if (c_sep || c_brk) begin
                        n_mode = ctt_pkg::MODE_IDLE;
                    end else if (c_bslash) begin
                        n_mode = ctt_pkg::MODE_ESCAPE;
                    end else begin
                        n_quoted = c_quote;
                        n_mode   = ctt_pkg::MODE_TOKEN;
                    end
                end
                ctt_pkg::MODE_COMMENT: begin
                    if (i_data_byte == ctt_pkg::CH_NL) begin
                        n_mode = ctt_pkg::MODE_IDLE;
                    end
                end
                ctt_pkg::MODE_TOKEN: begin
                    if (c_sep && !r_quoted) begin
                        n_mode = ctt_pkg::MODE_IDLE;
                    end else if (c_bslash) begin
                        n_mode = ctt_pkg::MODE_ESCAPE;
                    end else if (c_quote) begin
                        // closing quote ends the token
                        n_quoted = !r_quoted;
                        if (r_quoted) begin
                            n_mode = ctt_pkg::MODE_IDLE;
                        end
                    end
                end
                ctt_pkg::MODE_ESCAPE: begin
                    n_mode = ctt_pkg::MODE_TOKEN;
                end
                default: begin
                    n_mode = ctt_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // result word
    always_comb begin
        o_result = '0;
        if (i_action == ctt_pkg::ACT_EOS) begin
            o_result.emit      = (r_mode == ctt_pkg::MODE_TOKEN) ||
                                 (r_mode == ctt_pkg::MODE_ESCAPE);
            o_result.token_end = 1'b1;
        end else begin
            unique case (r_mode)
                ctt_pkg::MODE_IDLE: begin
                    if (!c_hash && !c_sep && !c_bslash) begin
                        o_result.emit       = 1'b1;
                        o_result.char_valid = 1'b1;
                        o_result.token_char = i_data_byte;
                        o_result.token_end  = c_brk;
                    end
                end
                ctt_pkg::MODE_COMMENT: begin
                    o_result = '0;
                end
                ctt_pkg::MODE_TOKEN: begin
                    if (c_sep && !r_quoted) begin
                        o_result.emit      = 1'b1;
                        o_result.token_end = 1'b1;
                    end else if (!c_bslash) begin
                        o_result.emit       = 1'b1;
                        o_result.char_valid = 1'b1;
                        o_result.token_char = i_data_byte;
                        o_result.token_end  = c_quote && r_quoted;
                    end
                end
                ctt_pkg::MODE_ESCAPE: begin
                    o_result.emit       = 1'b1;
                    o_result.char_valid = 1'b1;
                    o_result.token_char = i_data_byte;
                end
                default: begin
                    o_result = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ctt_pkg::MODE_IDLE;
            r_quoted <= 1'b0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_quoted <= n_quoted;
        end
    end

    // a quoted span only lives inside a token
    `CTT_ASSERT(a_quote_in_token, r_quoted,
        (r_mode == ctt_pkg::MODE_TOKEN) || (r_mode == ctt_pkg::MODE_ESCAPE),
        "quoted span outside a token")
    `CTT_ASSERT_NEXT(a_eos_clears, i_step && (i_action == ctt_pkg::ACT_EOS),
        (r_mode == ctt_pkg::MODE_IDLE) && !r_quoted,
        "end of stream did not return to idle")
    `CTT_ASSERT(a_char_end_kind, o_result.emit && o_result.char_valid && o_result.token_end,
        (o_result.token_char == ctt_pkg::CH_QUOTE) ||
        (o_result.token_char == ctt_pkg::CH_LBRACK) ||
        (o_result.token_char == ctt_pkg::CH_RBRACK),
        "token closed by an unexpected byte")

endmodule

// File: hdl/ctt_out_stage.sv
`timescale 1ns / 1ps

module ctt_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ctt_pkg::t_lex_result i_word,
    output logic                 o_free,
    ctt_out_if.source            o_out
);

    logic       r_valid;
    logic       r_char_valid;
    logic [7:0] r_token_char;
    logic       r_token_end;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char_valid <= i_word.char_valid;
            r_token_char <= i_word.token_char;
            r_token_end  <= i_word.token_end;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.char_valid = r_char_valid;
    assign o_out.token_char = r_token_char;
    assign o_out.token_end  = r_token_end;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1400;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] token_char;
        logic       token_end;
    } t_token_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctt_in_if  in_ch();
    ctt_out_if out_ch();

    config_text_tokenizer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // lexer state mirror
    ctt_pkg::t_lex_mode lex_state = ctt_pkg::MODE_IDLE;
    logic               in_quotes = 1'b0;
    t_token_word        predicted_word;
    t_token_word        expected_words[$];

    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   sent_words = 0;
    int   sink_hold = 0;
    logic fast_source = 1'b0;
    logic fast_sink = 1'b0;

    function automatic logic splits_token(input logic [7:0] c);
        case (c)
            ctt_pkg::CH_SPACE, ctt_pkg::CH_NL, ctt_pkg::CH_TAB, ctt_pkg::CH_COLON,
            ctt_pkg::CH_COMMA: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // ordinary token byte; a quote toggles the quoted span, the closing one ends the token
    function automatic logic take_token_byte(input logic [7:0] c, output t_token_word w);
        w = '{1'b1, c, 1'b0};
        lex_state = ctt_pkg::MODE_TOKEN;
        if (c == ctt_pkg::CH_QUOTE) begin
            in_quotes = !in_quotes;
            if (!in_quotes) begin
                lex_state = ctt_pkg::MODE_IDLE;
                w.token_end = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic tokenize_byte(input logic act, input logic [7:0] c,
                                           output t_token_word w);
        ctt_pkg::t_lex_mode cur;
        logic               produced;
        cur = lex_state;
        produced = 1'b0;
        w = '0;
        if (act == ctt_pkg::ACT_EOS) begin
            lex_state = ctt_pkg::MODE_IDLE;
            in_quotes = 1'b0;
            if (cur == ctt_pkg::MODE_TOKEN || cur == ctt_pkg::MODE_ESCAPE) begin
                w.token_end = 1'b1;
                produced = 1'b1;
            end
        end else begin
            case (cur)
                ctt_pkg::MODE_IDLE: begin
                    in_quotes = 1'b0;
                    if (c == ctt_pkg::CH_HASH) begin
                        lex_state = ctt_pkg::MODE_COMMENT;
                    end else if (!splits_token(c)) begin
                        if (c == ctt_pkg::CH_LBRACK || c == ctt_pkg::CH_RBRACK) begin
                            w = '{1'b1, c, 1'b1};
                            produced = 1'b1;
                        end else if (c == ctt_pkg::CH_BSLASH) begin
                            lex_state = ctt_pkg::MODE_ESCAPE;
                        end else begin
                            produced = take_token_byte(c, w);
                        end
                    end
                end
                ctt_pkg::MODE_COMMENT: begin
                    if (c == ctt_pkg::CH_NL) lex_state = ctt_pkg::MODE_IDLE;
                end
                ctt_pkg::MODE_TOKEN: begin
                    if (splits_token(c) && !in_quotes) begin
                        lex_state = ctt_pkg::MODE_IDLE;
                        w.token_end = 1'b1;
                        produced = 1'b1;
                    end else if (c == ctt_pkg::CH_BSLASH) begin
                        lex_state = ctt_pkg::MODE_ESCAPE;
                    end else begin
                        produced = take_token_byte(c, w);
                    end
                end
                default: begin
                    // escaped byte goes through as is
                    lex_state = ctt_pkg::MODE_TOKEN;
                    w = '{1'b1, c, 1'b0};
                    produced = 1'b1;
                end
            endcase
        end
        return produced;
    endfunction

    function automatic void check_word(input t_token_word got);
        t_token_word want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, got cv=%b ch=%02h end=%b",
                     $time, got.char_valid, got.token_char, got.token_end);
            mismatch_count++;
        end else begin
            want = expected_words.pop_front();
            if (got.char_valid !== want.char_valid) begin
                $display("%0t: char_valid expected %b got %b",
                         $time, want.char_valid, got.char_valid);
                mismatch_count++;
            end
            if (got.token_char !== want.token_char) begin
                $display("%0t: token_char expected %02h got %02h",
                         $time, want.token_char, got.token_char);
                mismatch_count++;
            end
            if (got.token_end !== want.token_end) begin
                $display("%0t: token_end expected %b got %b",
                         $time, want.token_end, got.token_end);
                mismatch_count++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                if (tokenize_byte(in_ch.action, in_ch.data_byte, predicted_word))
                    expected_words.push_back(predicted_word);
            end
            if (out_ch.valid && out_ch.ready)
                check_word('{out_ch.char_valid, out_ch.token_char, out_ch.token_end});
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stall per word, plus an occasional long hold-off
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (sink_hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end
            stall = fast_sink ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_word(input logic act, input logic [7:0] b);
        int gap;
        gap = fast_source ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_words++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h21, 8'h7E));
        while (b == ctt_pkg::CH_HASH || b == ctt_pkg::CH_QUOTE || b == ctt_pkg::CH_BSLASH ||
               b == ctt_pkg::CH_LBRACK || b == ctt_pkg::CH_RBRACK ||
               b == ctt_pkg::CH_COLON || b == ctt_pkg::CH_COMMA);
        return b;
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 4))
            0: return ctt_pkg::CH_SPACE;
            1: return ctt_pkg::CH_NL;
            2: return ctt_pkg::CH_TAB;
            3: return ctt_pkg::CH_COLON;
            default: return ctt_pkg::CH_COMMA;
        endcase
    endfunction

    // token body with the odd escape, quote, separator or high byte mixed in
    task automatic send_token();
        int len;
        int pick;
        len = $urandom_range(1, 6);
        repeat (len) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_BSLASH);
                send_word(ctt_pkg::ACT_DATA, 8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_QUOTE);
            end else if (pick == 2) begin
                send_word(ctt_pkg::ACT_DATA, pick_separator());
            end else if (pick == 3) begin
                send_word(ctt_pkg::ACT_DATA, 8'($urandom_range(8'h80, 8'hFF)));
            end else begin
                send_word(ctt_pkg::ACT_DATA, plain_byte());
            end
        end
    endtask

    task automatic test_separators();
        send_word(ctt_pkg::ACT_DATA, 8'h00);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_COMMA);
        send_word(ctt_pkg::ACT_DATA, 8'hFF);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_TAB);
        send_word(ctt_pkg::ACT_DATA, "k");
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_COLON);
        send_word(ctt_pkg::ACT_DATA, "v");
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_NL);
    endtask

    task automatic test_brackets();
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_LBRACK);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_RBRACK);
    endtask

    task automatic test_comments();
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_HASH);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_SPACE);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_NL);
    endtask

    task automatic test_escapes();
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_BSLASH);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_COLON);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_BSLASH);
        send_word(ctt_pkg::ACT_EOS, 8'h00);
    endtask

    task automatic test_quotes();
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_QUOTE);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_SPACE);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_QUOTE);
    endtask

    task automatic test_end_of_stream();
        send_word(ctt_pkg::ACT_DATA, "z");
        send_word(ctt_pkg::ACT_EOS, 8'hFF);
        send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_HASH);
        send_word(ctt_pkg::ACT_EOS, 8'h00);
        send_word(ctt_pkg::ACT_EOS, 8'h5A);
    endtask

    // hold the result side off while the sender keeps pushing, so the input stalls
    task automatic test_backpressure();
        fast_source = 1'b1;
        sink_hold = 200;
        repeat (20) begin
            send_word(ctt_pkg::ACT_DATA, plain_byte());
            send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_SPACE);
        end
        fast_source = 1'b0;
    endtask

    task automatic test_random_text();
        int         first;
        int         n;
        logic [7:0] b;
        first = sent_words;
        while (sent_words - first < RANDOM_WORDS) begin
            if ($urandom_range(0, 19) == 0) fast_source = !fast_source;
            if ($urandom_range(0, 19) == 0) fast_sink = !fast_sink;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_token();
                    send_word(ctt_pkg::ACT_DATA, pick_separator());
                    send_token();
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_NL);
                end
                3: begin
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_LBRACK);
                    send_token();
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_RBRACK);
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_NL);
                end
                4: begin
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_HASH);
                    n = $urandom_range(0, 8);
                    repeat (n) begin
                        b = 8'($urandom_range(0, 255));
                        send_word(ctt_pkg::ACT_DATA, (b == ctt_pkg::CH_NL) ?
                                  ctt_pkg::CH_SPACE : b);
                    end
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_NL);
                end
                5: begin
                    send_token();
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_COLON);
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_QUOTE);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        b = 8'($urandom_range(0, 255));
                        send_word(ctt_pkg::ACT_DATA, (b == ctt_pkg::CH_QUOTE) ?
                                  ctt_pkg::CH_COMMA : b);
                    end
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_QUOTE);
                    send_word(ctt_pkg::ACT_DATA, ctt_pkg::CH_NL);
                end
                6: begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_word(ctt_pkg::ACT_DATA, 8'($urandom_range(0, 255)));
                end
                7: send_word(ctt_pkg::ACT_EOS, 8'($urandom_range(0, 255)));
                default: begin
                    send_token();
                    send_word(ctt_pkg::ACT_DATA, pick_separator());
                end
            endcase
        end
        fast_source = 1'b0;
        fast_sink = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= ctt_pkg::ACT_DATA;
        in_ch.data_byte <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_separators();
        test_brackets();
        test_comments();
        test_escapes();
        test_quotes();
        test_end_of_stream();
        test_backpressure();
        test_random_text();
        in_ch.valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/ctt_pkg.sv
hdl/ctt_stream_if.sv
hdl/ctt_lex.sv
hdl/ctt_out_stage.sv
hdl/config_text_tokenizer_top.sv
sim/tb.sv
